// ===== hdl/i2cram_pkg.sv =====
// Shared constants for the I2C register access master.
// No dependencies; used by i2c_register_access_master.
`default_nettype none

package i2cram_pkg;

    // Tick kinds carried in tuser.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register map (byte addresses, one 32-bit register).
    localparam int unsigned APB_ADDR_W      = 3;
    localparam logic        REG_IDX_SLAVE   = 1'b0;
    localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h80;
    localparam logic [7:0]  READ_BIT        = 8'h01;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    // Quarter-bit positions inside one bit period.
    localparam logic [1:0] Q_SETUP  = 2'd0;
    localparam logic [1:0] Q_RISE   = 2'd1;
    localparam logic [1:0] Q_SAMPLE = 2'd2;
    localparam logic [1:0] Q_FALL   = 2'd3;

    // Bit count at which the acknowledge slot is reached.
    localparam logic [3:0] ACK_SLOT = 4'd8;

endpackage

`default_nettype wire

// ===== hdl/i2c_register_access_master.sv =====
// I2C master running 16-bit register write and read transactions to one slave.
// Depends on i2cram_pkg for kind codes, register map and widths.
`default_nettype none

// Each stream transaction on the slave side is one quarter-bit tick of the I2C
// bus; it carries the sampled SDA level and may start a register write or read
// while the master is idle. Every tick returns exactly one result with the SCL
// and SDA drive levels, busy, done, the last read value and a sticky flag that
// is set when the slave fails to acknowledge a sent byte. One tick is taken
// per clock cycle while the master side is not stalled; a tick passes through
// an input register and then a result register before its result is
// presented on the master side. The slave address is written through the APB
// port at byte address 0 and should only be changed while the bus is idle.
module i2c_register_access_master (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [i2cram_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    // Tick input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // reg_addr[7:0], write_data[23:8], sda_in[24], zero[31:25]
    input  wire logic [i2cram_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  wire logic [1:0]                        s_tuser,
    // Result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[19:4],
    // nack_seen[20], zero[23:21]
    output logic      [i2cram_pkg::M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_ADDR, PH_PTR, PH_HI, PH_LO,
        PH_RESTART, PH_ADDR_RD, PH_RX_HI, PH_RX_LO, PH_STOP
    } phase_t;

    // Configuration and pipeline registers.
    logic [7:0]  slave_addr_reg;
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [7:0]  in_ptr_reg;
    logic [15:0] in_value_reg;
    logic        in_sda_reg;
    logic        out_valid_reg;
    logic [i2cram_pkg::M_TDATA_W-1:0] out_data_reg;

    // Bus state.
    phase_t      phase_reg,   phase_next;
    logic [1:0]  quarter_reg, quarter_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg,   shift_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  pointer_reg, pointer_next;
    logic [15:0] value_reg,   value_next;
    logic        nack_reg,    nack_next;
    logic [15:0] last_read_reg, last_read_next;

    logic        advance;
    logic        cfg_write;
    logic        start;
    phase_t      ph;
    logic [1:0]  q;
    logic        scl, sda, busy, done, end_phase, ack_slot, tx, rx;
    logic [i2cram_pkg::M_TDATA_W-1:0] result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == i2cram_pkg::REG_IDX_SLAVE) ? {24'd0, slave_addr_reg} : 32'd0;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        start = (phase_reg == PH_IDLE)
            && (in_kind_reg == i2cram_pkg::KIND_WRITE || in_kind_reg == i2cram_pkg::KIND_READ);

        // A start loads the transaction state and runs the first quarter at once.
        ph             = start ? PH_START : phase_reg;
        q              = start ? i2cram_pkg::Q_SETUP : quarter_reg;
        bit_count_next = start ? 4'd0 : bit_count_reg;
        shift_next     = start ? 8'd0 : shift_reg;
        is_read_next   = start ? (in_kind_reg == i2cram_pkg::KIND_READ) : is_read_reg;
        pointer_next   = start ? in_ptr_reg : pointer_reg;
        value_next     = start ? in_value_reg : value_reg;
        nack_next      = start ? 1'b0 : nack_reg;
        last_read_next = last_read_reg;
        quarter_next   = q;
        phase_next     = ph;

        scl       = 1'b1;
        sda       = 1'b1;
        done      = 1'b0;
        end_phase = 1'b0;
        busy      = (ph != PH_IDLE);
        tx        = (ph == PH_ADDR || ph == PH_PTR || ph == PH_HI || ph == PH_LO
                     || ph == PH_ADDR_RD);
        rx        = (ph == PH_RX_HI || ph == PH_RX_LO);
        ack_slot  = (bit_count_next >= i2cram_pkg::ACK_SLOT);

        if (ph == PH_START || ph == PH_RESTART) begin
            scl       = (q == i2cram_pkg::Q_RISE || q == i2cram_pkg::Q_SAMPLE);
            sda       = (q == i2cram_pkg::Q_SETUP || q == i2cram_pkg::Q_RISE);
            end_phase = (q == i2cram_pkg::Q_FALL);
        end else if (ph == PH_STOP) begin
            scl       = (q != i2cram_pkg::Q_SETUP);
            sda       = (q == i2cram_pkg::Q_SAMPLE || q == i2cram_pkg::Q_FALL);
            end_phase = (q == i2cram_pkg::Q_FALL);
            done      = end_phase;
        end else if (tx || rx) begin
            scl = (q == i2cram_pkg::Q_RISE || q == i2cram_pkg::Q_SAMPLE);
            if (tx) begin
                sda = ack_slot ? 1'b1 : shift_next[7];
            end else begin
                // Acknowledge the high byte, leave the low byte unacknowledged.
                sda = ack_slot ? (ph != PH_RX_HI) : 1'b1;
            end
            if (q == i2cram_pkg::Q_SAMPLE) begin
                if (tx && ack_slot && in_sda_reg) begin
                    nack_next = 1'b1;
                end
                if (rx && !ack_slot) begin
                    shift_next = {shift_next[6:0], in_sda_reg};
                end
            end
            if (q == i2cram_pkg::Q_FALL) begin
                if (tx && !ack_slot) begin
                    shift_next = {shift_next[6:0], 1'b0};
                end
                if (ack_slot) begin
                    end_phase = 1'b1;
                    if (ph == PH_RX_HI) begin
                        value_next = {shift_next, 8'd0};
                    end else if (ph == PH_RX_LO) begin
                        last_read_next = {value_next[15:8], shift_next};
                    end
                end else begin
                    bit_count_next = bit_count_next + 4'd1;
                end
            end
        end else begin
            phase_next = PH_IDLE;
        end

        if (ph != PH_IDLE) begin
            if (end_phase) begin
                case (ph)
                    PH_START:   phase_next = PH_ADDR;
                    PH_ADDR:    phase_next = PH_PTR;
                    PH_PTR:     phase_next = is_read_next ? PH_RESTART : PH_HI;
                    PH_HI:      phase_next = PH_LO;
                    PH_LO:      phase_next = PH_STOP;
                    PH_RESTART: phase_next = PH_ADDR_RD;
                    PH_ADDR_RD: phase_next = PH_RX_HI;
                    PH_RX_HI:   phase_next = PH_RX_LO;
                    PH_RX_LO:   phase_next = PH_STOP;
                    default:    phase_next = PH_IDLE;
                endcase
                quarter_next   = i2cram_pkg::Q_SETUP;
                bit_count_next = 4'd0;
                case (phase_next)
                    PH_ADDR:    shift_next = slave_addr_reg;
                    PH_PTR:     shift_next = pointer_next;
                    PH_HI:      shift_next = value_next[15:8];
                    PH_LO:      shift_next = value_next[7:0];
                    PH_ADDR_RD: shift_next = slave_addr_reg + i2cram_pkg::READ_BIT;
                    default:    shift_next = 8'd0;
                endcase
            end else begin
                quarter_next = q + 2'd1;
            end
        end

        result = {3'd0, nack_next, last_read_next, done, busy, sda, scl};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= i2cram_pkg::SLAVE_ADDR_RST;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            quarter_reg    <= 2'd0;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            is_read_reg    <= 1'b0;
            pointer_reg    <= 8'd0;
            value_reg      <= 16'd0;
            nack_reg       <= 1'b0;
            last_read_reg  <= 16'd0;
        end else begin
            if (cfg_write && paddr[2] == i2cram_pkg::REG_IDX_SLAVE) begin
                slave_addr_reg <= pwdata[7:0];
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                quarter_reg   <= quarter_next;
                bit_count_reg <= bit_count_next;
                shift_reg     <= shift_next;
                is_read_reg   <= is_read_next;
                pointer_reg   <= pointer_next;
                value_reg     <= value_next;
                nack_reg      <= nack_next;
                last_read_reg <= last_read_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg  <= s_tuser;
            in_ptr_reg   <= s_tdata[7:0];
            in_value_reg <= s_tdata[23:8];
            in_sda_reg   <= s_tdata[24];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> quarter_reg == 2'd0 && bit_count_reg == 4'd0)
        else $error("idle master holds a non-zero bit position");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= i2cram_pkg::ACK_SLOT)
        else $error("bit counter ran past the acknowledge slot");

    a_framing_no_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START || phase_reg == PH_RESTART || phase_reg == PH_STOP)
        |-> bit_count_reg == 4'd0)
        else $error("bit counter moved during a start or stop condition");

    a_done_ends_transaction: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && done |=> phase_reg == PH_IDLE && out_data_reg[2])
        else $error("done reported without returning to idle");

    a_stalled_tick_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("queued tick lost while the result side stalled");

endmodule

`default_nettype wire

// ===== tb/tb_i2c_register_access_master.sv =====
// Self-checking testbench for the I2C register access master: drives quarter-bit
// ticks and APB writes, predicts every result tick in a bus model of its own.
// Depends on i2cram_pkg and i2c_register_access_master.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES  = 64;
    localparam int         DRAIN_CYCLES = 6;

    typedef enum logic [4:0] {
        BUS_IDLE, BUS_START, SEND_ADDR, SEND_PTR, SEND_HI, SEND_LO,
        BUS_RESTART, SEND_ADDR_RD, RECV_HI, RECV_LO, BUS_STOP
    } bus_phase_t;

    typedef struct {
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [15:0] rdata;
        logic        nack;
    } bus_levels_t;

    logic                                  aclk     = 1'b0;
    logic                                  aresetn  = 1'b0;
    logic                                  psel     = 1'b0;
    logic                                  penable  = 1'b0;
    logic                                  pwrite   = 1'b0;
    logic [i2cram_pkg::APB_ADDR_W-1:0]     paddr    = '0;
    logic [31:0]                           pwdata   = '0;
    logic [31:0]                           prdata;
    logic                                  pready;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [i2cram_pkg::S_TDATA_W-1:0]      s_tdata  = '0;
    logic [1:0]                            s_tuser  = i2cram_pkg::KIND_TICK;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [i2cram_pkg::M_TDATA_W-1:0]      m_tdata;

    // Bus model state
    bus_phase_t  bus_phase;
    logic [1:0]  quarter;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic        rd_mode;
    logic [7:0]  ptr_reg;
    logic [15:0] word_reg;
    logic        nack_sticky;
    logic [15:0] last_word;
    logic [7:0]  slave_addr;

    bus_levels_t pending_levels[$];
    int          mismatch_count = 0;
    bit          steady         = 1'b0;
    bit          hold_request   = 1'b0;

    i2c_register_access_master dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit sending(input bus_phase_t p);
        return p == SEND_ADDR || p == SEND_PTR || p == SEND_HI || p == SEND_LO ||
               p == SEND_ADDR_RD;
    endfunction

    function automatic bit receiving(input bus_phase_t p);
        return p == RECV_HI || p == RECV_LO;
    endfunction

    function automatic void load_phase(input bus_phase_t p);
        bus_phase = p;
        quarter   = '0;
        bit_cnt   = '0;
        case (p)
            SEND_ADDR:    shifter = slave_addr;
            SEND_PTR:     shifter = ptr_reg;
            SEND_HI:      shifter = word_reg[15:8];
            SEND_LO:      shifter = word_reg[7:0];
            SEND_ADDR_RD: shifter = slave_addr + i2cram_pkg::READ_BIT;
            default:      shifter = '0;
        endcase
    endfunction

    function automatic bus_phase_t following_phase(input bus_phase_t p);
        case (p)
            BUS_START:    return SEND_ADDR;
            SEND_ADDR:    return SEND_PTR;
            SEND_PTR:     return rd_mode ? BUS_RESTART : SEND_HI;
            SEND_HI:      return SEND_LO;
            SEND_LO:      return BUS_STOP;
            BUS_RESTART:  return SEND_ADDR_RD;
            SEND_ADDR_RD: return RECV_HI;
            RECV_HI:      return RECV_LO;
            RECV_LO:      return BUS_STOP;
            default:      return BUS_IDLE;
        endcase
    endfunction

    // Advances the bus model by one tick and returns the line levels it drives.
    function automatic bus_levels_t advance_bus(input logic [1:0] kind, input logic [7:0] ptr,
                                                input logic [15:0] word, input logic sda_in);
        bus_levels_t r;
        logic [1:0]  q;
        logic        finish;
        logic        ack;
        logic        tx;
        logic        rx;
        r.scl  = 1'b1;
        r.sda  = 1'b1;
        r.done = 1'b0;
        finish = 1'b0;
        if (bus_phase == BUS_IDLE
            && (kind == i2cram_pkg::KIND_WRITE || kind == i2cram_pkg::KIND_READ)) begin
            rd_mode     = (kind == i2cram_pkg::KIND_READ);
            ptr_reg     = ptr;
            word_reg    = word;
            nack_sticky = 1'b0;
            load_phase(BUS_START);
        end
        q      = quarter;
        r.busy = (bus_phase != BUS_IDLE);
        tx     = sending(bus_phase);
        rx     = receiving(bus_phase);
        if (bus_phase == BUS_START || bus_phase == BUS_RESTART) begin
            r.scl  = (q == i2cram_pkg::Q_RISE || q == i2cram_pkg::Q_SAMPLE);
            r.sda  = (q == i2cram_pkg::Q_SETUP || q == i2cram_pkg::Q_RISE);
            finish = (q == i2cram_pkg::Q_FALL);
        end else if (bus_phase == BUS_STOP) begin
            r.scl = (q != i2cram_pkg::Q_SETUP);
            r.sda = (q == i2cram_pkg::Q_SAMPLE || q == i2cram_pkg::Q_FALL);
            if (q == i2cram_pkg::Q_FALL) begin
                finish = 1'b1;
                r.done = 1'b1;
            end
        end else if (tx || rx) begin
            ack   = (bit_cnt >= i2cram_pkg::ACK_SLOT);
            r.scl = (q == i2cram_pkg::Q_RISE || q == i2cram_pkg::Q_SAMPLE);
            if (tx)
                r.sda = ack ? 1'b1 : shifter[7];
            else
                r.sda = ack ? (bus_phase != RECV_HI) : 1'b1;
            if (q == i2cram_pkg::Q_SAMPLE) begin
                if (tx && ack && sda_in)
                    nack_sticky = 1'b1;
                if (rx && !ack)
                    shifter = {shifter[6:0], sda_in};
            end
            if (q == i2cram_pkg::Q_FALL) begin
                if (tx && !ack)
                    shifter = {shifter[6:0], 1'b0};
                if (ack) begin
                    finish = 1'b1;
                    if (bus_phase == RECV_HI)
                        word_reg = {shifter, 8'h00};
                    else if (bus_phase == RECV_LO)
                        last_word = {word_reg[15:8], shifter};
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                end
            end
        end else begin
            bus_phase = BUS_IDLE;
        end
        if (bus_phase != BUS_IDLE) begin
            if (finish)
                load_phase(following_phase(bus_phase));
            else
                quarter = q + 2'd1;
        end
        r.rdata = last_word;
        r.nack  = nack_sticky;
        return r;
    endfunction

    // Picks the SDA level the slave shows on the next tick.
    function automatic logic pick_sda(input int nack_pct, input int rx_fill);
        if (sending(bus_phase) && bit_cnt >= i2cram_pkg::ACK_SLOT)
            return $urandom_range(1, 100) <= nack_pct;
        if (receiving(bus_phase) && bit_cnt < i2cram_pkg::ACK_SLOT && rx_fill != 2)
            return rx_fill[0];
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string what, input int expected_v, input int got_v);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, expected_v, got_v);
        mismatch_count++;
    endtask

    task automatic send_tick(input logic [1:0] kind, input logic [7:0] ptr,
                             input logic [15:0] word, input logic sda);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, sda, word, ptr};
        do @(posedge aclk); while (!s_tready);
        pending_levels.push_back(advance_bus(kind, ptr, word, sda));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only called with the bus idle and every result collected.
    task automatic set_slave_address(input logic [7:0] addr);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {i2cram_pkg::REG_IDX_SLAVE, 2'b00};
        pwdata  <= {24'd0, addr};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        slave_addr = addr;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_transfer(input logic [1:0] start_kind, input logic [7:0] ptr,
                                input logic [15:0] word, input int nack_pct,
                                input int rx_fill, input bit noisy);
        logic [1:0] k;
        send_tick(start_kind, ptr, word, pick_sda(nack_pct, rx_fill));
        while (bus_phase != BUS_IDLE) begin
            k = noisy ? 2'($urandom_range(0, 3)) : i2cram_pkg::KIND_TICK;
            send_tick(k, 8'($urandom), 16'($urandom), pick_sda(nack_pct, rx_fill));
        end
    endtask

    task automatic send_idle_noise(input int count);
        repeat (count)
            send_tick($urandom_range(0, 1) ? i2cram_pkg::KIND_TICK : KIND_UNUSED, 8'($urandom),
                      16'($urandom), 1'($urandom));
    endtask

    task automatic test_idle_ticks();
        send_tick(i2cram_pkg::KIND_TICK, 8'h00, 16'h0000, 1'b0);
        send_tick(KIND_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
        send_tick(i2cram_pkg::KIND_TICK, 8'hFF, 16'hFFFF, 1'b1);
        send_tick(KIND_UNUSED, 8'h00, 16'h0000, 1'b0);
    endtask

    // Every sent byte goes unacknowledged, so the flag sets and stays set.
    task automatic test_missing_ack();
        run_transfer(i2cram_pkg::KIND_WRITE, 8'hFF, 16'h0000, 100, 2, 1'b0);
    endtask

    // The all-ones address wraps to zero for the read address. The flag left by the
    // previous transfer clears at this start, and start requests while busy are ignored.
    task automatic test_read_address_wrap();
        set_slave_address(8'hFF);
        run_transfer(i2cram_pkg::KIND_READ, 8'h00, 16'hFFFF, 0, 2, 1'b1);
    endtask

    task automatic test_result_backpressure();
        hold_request = 1'b1;
        send_idle_noise(30);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        send_idle_noise(20);
        steady = 1'b0;
    endtask

    // Result collector: compares each transaction with the oldest prediction.
    initial begin
        bus_levels_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_levels.size() == 0) begin
                    $display("unexpected result at %0t: %h", $realtime, m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_levels.pop_front();
                    if (m_tdata[0] !== want.scl)
                        report_mismatch("scl_out", want.scl, m_tdata[0]);
                    if (m_tdata[1] !== want.sda)
                        report_mismatch("sda_out", want.sda, m_tdata[1]);
                    if (m_tdata[2] !== want.busy)
                        report_mismatch("busy_res", want.busy, m_tdata[2]);
                    if (m_tdata[3] !== want.done)
                        report_mismatch("done_res", want.done, m_tdata[3]);
                    if (m_tdata[19:4] !== want.rdata)
                        report_mismatch("read_data", want.rdata, m_tdata[19:4]);
                    if (m_tdata[20] !== want.nack)
                        report_mismatch("nack_seen", want.nack, m_tdata[20]);
                end
            end
        end
    end

    // Result receiver: random stalls, one long hold on request.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
            end
        end
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        bus_phase   = BUS_IDLE;
        quarter     = '0;
        bit_cnt     = '0;
        shifter     = '0;
        rd_mode     = 1'b0;
        ptr_reg     = '0;
        word_reg    = '0;
        nack_sticky = 1'b0;
        last_word   = '0;
        slave_addr  = i2cram_pkg::SLAVE_ADDR_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_ticks();
        test_missing_ack();
        test_read_address_wrap();
        test_result_backpressure();
        test_steady_stream();
        wait_drained();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
